@@ sv/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg
// Shared codes, character constants, keyword table and helper functions for
// the source text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    localparam int POS_BITS_DEF  = 24;
    localparam int LINE_BITS_DEF = 20;

    localparam int KIND_W = 6;
    localparam int ERR_W  = 3;
    localparam int TAG_W  = KIND_W + ERR_W;
    localparam int KW_W   = 48;
    localparam int KW_LEN = 6;
    localparam int KW_NUM = 9;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // lexer modes
    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_INT   = 3'd1;
    localparam logic [2:0] M_FRAC  = 3'd2;
    localparam logic [2:0] M_IDENT = 3'd3;
    localparam logic [2:0] M_STR   = 3'd4;
    localparam logic [2:0] M_CMT   = 3'd5;
    localparam logic [2:0] M_PEND  = 3'd6;
    localparam logic [2:0] M_HALT  = 3'd7;

    // pending operator codes
    localparam logic [2:0] P_NONE  = 3'd0;
    localparam logic [2:0] P_EQ    = 3'd1;
    localparam logic [2:0] P_BANG  = 3'd2;
    localparam logic [2:0] P_LT    = 3'd3;
    localparam logic [2:0] P_GT    = 3'd4;
    localparam logic [2:0] P_AMP   = 3'd5;
    localparam logic [2:0] P_BAR   = 3'd6;
    localparam logic [2:0] P_SLASH = 3'd7;

    // token kinds
    localparam logic [KIND_W-1:0] K_EOF    = 6'd0;
    localparam logic [KIND_W-1:0] K_NUM    = 6'd1;
    localparam logic [KIND_W-1:0] K_IDENT  = 6'd2;
    localparam logic [KIND_W-1:0] K_STR    = 6'd3;
    localparam logic [KIND_W-1:0] K_KW0    = 6'd4;
    localparam logic [KIND_W-1:0] K_ASSIGN = 6'd13;
    localparam logic [KIND_W-1:0] K_EQ     = 6'd14;
    localparam logic [KIND_W-1:0] K_NOT    = 6'd15;
    localparam logic [KIND_W-1:0] K_NE     = 6'd16;
    localparam logic [KIND_W-1:0] K_LT     = 6'd17;
    localparam logic [KIND_W-1:0] K_LE     = 6'd18;
    localparam logic [KIND_W-1:0] K_GT     = 6'd19;
    localparam logic [KIND_W-1:0] K_GE     = 6'd20;
    localparam logic [KIND_W-1:0] K_ANDAND = 6'd21;
    localparam logic [KIND_W-1:0] K_OROR   = 6'd22;
    localparam logic [KIND_W-1:0] K_PLUS   = 6'd23;
    localparam logic [KIND_W-1:0] K_MINUS  = 6'd24;
    localparam logic [KIND_W-1:0] K_STAR   = 6'd25;
    localparam logic [KIND_W-1:0] K_SLASH  = 6'd26;
    localparam logic [KIND_W-1:0] K_PCT    = 6'd27;
    localparam logic [KIND_W-1:0] K_LPAREN = 6'd28;
    localparam logic [KIND_W-1:0] K_RPAREN = 6'd29;
    localparam logic [KIND_W-1:0] K_LBRACE = 6'd30;
    localparam logic [KIND_W-1:0] K_RBRACE = 6'd31;
    localparam logic [KIND_W-1:0] K_SEMI   = 6'd32;
    localparam logic [KIND_W-1:0] K_COMMA  = 6'd33;

    // error codes
    localparam logic [ERR_W-1:0] E_NONE   = 3'd0;
    localparam logic [ERR_W-1:0] E_UNEXP  = 3'd1;
    localparam logic [ERR_W-1:0] E_AMP    = 3'd2;
    localparam logic [ERR_W-1:0] E_BAR    = 3'd3;
    localparam logic [ERR_W-1:0] E_UNTERM = 3'd4;

    // characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQ     = 8'h22;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // keywords packed little-endian, first character in the low byte
    localparam logic [KW_W-1:0] KW_TABLE [KW_NUM] = '{
        48'h000000726176,   // var
        48'h00746E697270,   // print
        48'h000000006669,   // if
        48'h000065736C65,   // else
        48'h00656C696877,   // while
        48'h000000006E66,   // fn
        48'h6E7275746572,   // return
        48'h000065757274,   // true
        48'h0065736C6166    // false
    };

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ERR_W-1:0]  err;
    } stt_tag_t;

    typedef struct packed {
        logic full;
        logic empty;
    } stt_qstat_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    // keyword kind for a packed prefix, or plain identifier
    function automatic logic [KIND_W-1:0] kw_kind(input logic [KW_W-1:0] kwb);
        logic [KIND_W-1:0] k;
        k = K_IDENT;
        for (int i = 0; i < KW_NUM; i++) begin
            if (kwb == KW_TABLE[i]) begin
                k = K_KW0 + KIND_W'(i);
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

@@ sv/stt_byte_if.sv @@
// ----------------------------------------------------------------------------
// stt_byte_if
// Source byte channel: one byte or an end marker per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface stt_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink   (input valid, input ch, input is_end, output ready);

endinterface

`default_nettype wire

@@ sv/stt_token_if.sv @@
// ----------------------------------------------------------------------------
// stt_token_if
// Token channel: one token descriptor per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface stt_token_if #(
    parameter int POS_BITS  = stt_pkg::POS_BITS_DEF,
    parameter int LINE_BITS = stt_pkg::LINE_BITS_DEF
);

    logic                        valid;
    logic                        ready;
    logic [stt_pkg::KIND_W-1:0]  kind;
    logic [LINE_BITS-1:0]        tok_line;
    logic [POS_BITS-1:0]         start_res;
    logic [POS_BITS-1:0]         length;
    logic [stt_pkg::ERR_W-1:0]   err;
    logic                        last;

    modport source (output valid, output kind, output tok_line, output start_res,
                    output length, output err, output last, input ready);
    modport sink   (input valid, input kind, input tok_line, input start_res,
                    input length, input err, input last, output ready);

endinterface

`default_nettype wire

@@ sv/stt_front.sv @@
// ----------------------------------------------------------------------------
// stt_front
// Lexer state machine: classify each accepted byte, update the token state
// and form up to two finished tokens per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_front #(
    parameter int  POS_BITS  = stt_pkg::POS_BITS_DEF,
    parameter int  LINE_BITS = stt_pkg::LINE_BITS_DEF,
    localparam int TOK_W     = stt_pkg::TAG_W + LINE_BITS + 2 * POS_BITS,
    localparam int ENT_W     = 2 * TOK_W + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       ch,
    input  logic             is_end,
    output logic             push,
    output logic [ENT_W-1:0] entry
);

    import stt_pkg::*;

    localparam logic [POS_BITS-1:0]  LEN0  = '0;
    localparam logic [POS_BITS-1:0]  LEN1  = POS_BITS'(1);
    localparam logic [POS_BITS-1:0]  LEN2  = POS_BITS'(2);
    localparam logic [POS_BITS-1:0]  KWMAX = POS_BITS'(KW_LEN);
    localparam logic [LINE_BITS-1:0] LINE1 = LINE_BITS'(1);

    logic [2:0]           mode_reg,   mode_next;
    logic [2:0]           pend_reg,   pend_next;
    logic [KW_W-1:0]      kw_reg,     kw_next;
    logic [POS_BITS-1:0]  tlen_reg,   tlen_next;
    logic [POS_BITS-1:0]  tstart_reg, tstart_next;
    logic [LINE_BITS-1:0] tline_reg,  tline_next;
    logic [POS_BITS-1:0]  pos_reg,    pos_next;
    logic [LINE_BITS-1:0] line_reg,   line_next;

    // flushed token (pending token closed by this byte) and second token
    logic                 f_v, s_v;
    stt_tag_t             f_tag, s_tag;
    logic [LINE_BITS-1:0] f_line, s_line;
    logic [POS_BITS-1:0]  f_start, s_start, f_len, s_len;

    logic                 run_idle;
    logic                 go;
    logic [2:0]           go_mode;
    logic [POS_BITS-1:0]  go_start;
    logic [KIND_W-1:0]    one_kind;

    function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] v);
        return (v == '1) ? v : v + POS_BITS'(1);
    endfunction

    function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
        return (v == '1) ? v : v + LINE_BITS'(1);
    endfunction

    // single-character kind for = ! < > when no '=' follows
    always_comb begin
        case (pend_reg)
            P_EQ:    one_kind = K_ASSIGN;
            P_BANG:  one_kind = K_NOT;
            P_LT:    one_kind = K_LT;
            default: one_kind = K_GT;
        endcase
    end

    always_comb begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        kw_next     = kw_reg;
        tlen_next   = tlen_reg;
        tstart_next = tstart_reg;
        tline_next  = tline_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;

        f_v     = 1'b0;
        f_tag   = '{kind: K_EOF, err: E_NONE};
        f_line  = tline_reg;
        f_start = tstart_reg;
        f_len   = tlen_reg;
        s_v     = 1'b0;
        s_tag   = '{kind: K_EOF, err: E_NONE};
        s_line  = line_reg;
        s_start = pos_reg;
        s_len   = LEN0;

        run_idle = 1'b0;
        go       = 1'b0;
        go_mode  = M_IDLE;
        go_start = pos_reg;

        if (is_end) begin
            // flush the open token, then EOF unless an error halts
            s_v = 1'b1;
            case (mode_reg)
                M_HALT:  s_v = 1'b0;
                M_INT, M_FRAC:
                begin
                    f_v       = 1'b1;
                    f_tag.kind = K_NUM;
                end
                M_IDENT:
                begin
                    f_v        = 1'b1;
                    f_tag.kind = (tlen_reg <= KWMAX) ? kw_kind(kw_reg) : K_IDENT;
                end
                M_STR:
                begin
                    f_v       = 1'b1;
                    f_tag.err = E_UNTERM;
                    f_line    = line_reg;
                    f_len     = LEN0;
                    s_v       = 1'b0;
                    mode_next = M_HALT;
                end
                M_PEND:
                begin
                    f_v   = 1'b1;
                    f_len = LEN1;
                    if (pend_reg == P_AMP || pend_reg == P_BAR) begin
                        f_tag.err = (pend_reg == P_AMP) ? E_AMP : E_BAR;
                        f_line    = line_reg;
                        f_len     = LEN0;
                        s_v       = 1'b0;
                        mode_next = M_HALT;
                    end else if (pend_reg == P_SLASH) begin
                        f_tag.kind = K_SLASH;
                    end else begin
                        f_tag.kind = one_kind;
                    end
                end
                default: ;
            endcase
            if (s_v) begin
                // EOF, then rewind for the next source
                mode_next = M_IDLE;
                pend_next = P_NONE;
                pos_next  = '0;
                line_next = LINE1;
            end
        end else begin
            pos_next = pos_inc(pos_reg);
            case (mode_reg)
                M_HALT: ;
                M_INT:
                begin
                    if (is_digit(ch)) begin
                        tlen_next = pos_inc(tlen_reg);
                    end else if (ch == CH_DOT) begin
                        tlen_next = pos_inc(tlen_reg);
                        mode_next = M_FRAC;
                    end else begin
                        f_v        = 1'b1;
                        f_tag.kind = K_NUM;
                        run_idle   = 1'b1;
                    end
                end
                M_FRAC:
                begin
                    if (is_digit(ch)) begin
                        tlen_next = pos_inc(tlen_reg);
                    end else begin
                        f_v        = 1'b1;
                        f_tag.kind = K_NUM;
                        run_idle   = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_word(ch)) begin
                        for (int i = 0; i < KW_LEN; i++) begin
                            if (tlen_reg == POS_BITS'(i)) begin
                                kw_next[8*i +: 8] = ch;
                            end
                        end
                        tlen_next = pos_inc(tlen_reg);
                    end else begin
                        f_v        = 1'b1;
                        f_tag.kind = (tlen_reg <= KWMAX) ? kw_kind(kw_reg) : K_IDENT;
                        run_idle   = 1'b1;
                    end
                end
                M_STR:
                begin
                    if (ch == CH_DQ) begin
                        f_v        = 1'b1;
                        f_tag.kind = K_STR;
                        f_line     = line_reg;
                        mode_next  = M_IDLE;
                    end else begin
                        if (ch == CH_LF) begin
                            line_next = line_inc(line_reg);
                        end
                        tlen_next = pos_inc(tlen_reg);
                    end
                end
                M_CMT:
                begin
                    run_idle = (ch == CH_LF);
                end
                M_PEND:
                begin
                    if (pend_reg == P_SLASH) begin
                        if (ch == CH_SLASH) begin
                            mode_next = M_CMT;
                        end else begin
                            f_v        = 1'b1;
                            f_tag.kind = K_SLASH;
                            f_len      = LEN1;
                            run_idle   = 1'b1;
                        end
                    end else if (pend_reg == P_AMP || pend_reg == P_BAR) begin
                        f_v = 1'b1;
                        if (ch == ((pend_reg == P_AMP) ? CH_AMP : CH_BAR)) begin
                            f_tag.kind = (pend_reg == P_AMP) ? K_ANDAND : K_OROR;
                            f_len      = LEN2;
                            mode_next  = M_IDLE;
                        end else begin
                            f_tag.err = (pend_reg == P_AMP) ? E_AMP : E_BAR;
                            f_line    = line_reg;
                            f_len     = LEN0;
                            mode_next = M_HALT;
                        end
                    end else begin
                        f_v = 1'b1;
                        if (ch == CH_EQ) begin
                            f_tag.kind = one_kind + KIND_W'(1);
                            f_len      = LEN2;
                            mode_next  = M_IDLE;
                        end else begin
                            f_tag.kind = one_kind;
                            f_len      = LEN1;
                            run_idle   = 1'b1;
                        end
                    end
                end
                default: run_idle = 1'b1;
            endcase

            if (run_idle) begin
                mode_next = M_IDLE;
                s_line    = line_reg;
                s_start   = pos_reg;
                s_len     = LEN1;
                case (ch)
                    CH_SP, CH_TAB, CH_CR: ;
                    CH_LF:     line_next = line_inc(line_reg);
                    CH_DQ:
                    begin
                        go       = 1'b1;
                        go_mode  = M_STR;
                        go_start = pos_inc(pos_reg);
                    end
                    CH_EQ:     begin go = 1'b1; go_mode = M_PEND; pend_next = P_EQ;    end
                    CH_BANG:   begin go = 1'b1; go_mode = M_PEND; pend_next = P_BANG;  end
                    CH_LT:     begin go = 1'b1; go_mode = M_PEND; pend_next = P_LT;    end
                    CH_GT:     begin go = 1'b1; go_mode = M_PEND; pend_next = P_GT;    end
                    CH_AMP:    begin go = 1'b1; go_mode = M_PEND; pend_next = P_AMP;   end
                    CH_BAR:    begin go = 1'b1; go_mode = M_PEND; pend_next = P_BAR;   end
                    CH_SLASH:  begin go = 1'b1; go_mode = M_PEND; pend_next = P_SLASH; end
                    CH_PLUS:   begin s_v = 1'b1; s_tag.kind = K_PLUS;   end
                    CH_MINUS:  begin s_v = 1'b1; s_tag.kind = K_MINUS;  end
                    CH_STAR:   begin s_v = 1'b1; s_tag.kind = K_STAR;   end
                    CH_PCT:    begin s_v = 1'b1; s_tag.kind = K_PCT;    end
                    CH_LPAREN: begin s_v = 1'b1; s_tag.kind = K_LPAREN; end
                    CH_RPAREN: begin s_v = 1'b1; s_tag.kind = K_RPAREN; end
                    CH_LBRACE: begin s_v = 1'b1; s_tag.kind = K_LBRACE; end
                    CH_RBRACE: begin s_v = 1'b1; s_tag.kind = K_RBRACE; end
                    CH_SEMI:   begin s_v = 1'b1; s_tag.kind = K_SEMI;   end
                    CH_COMMA:  begin s_v = 1'b1; s_tag.kind = K_COMMA;  end
                    default:
                    begin
                        if (is_digit(ch)) begin
                            go      = 1'b1;
                            go_mode = M_INT;
                        end else if (is_alpha(ch) || ch == CH_UNDER) begin
                            go      = 1'b1;
                            go_mode = M_IDENT;
                        end else begin
                            s_v       = 1'b1;
                            s_tag.err = E_UNEXP;
                            s_len     = LEN0;
                            mode_next = M_HALT;
                        end
                    end
                endcase
                if (go) begin
                    mode_next   = go_mode;
                    tstart_next = go_start;
                    tline_next  = line_reg;
                    tlen_next   = (go_mode == M_STR) ? LEN0 : LEN1;
                    kw_next     = (go_mode == M_IDENT) ? {{(KW_W-8){1'b0}}, ch} : '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg   <= M_IDLE;
            pend_reg   <= P_NONE;
            kw_reg     <= '0;
            tlen_reg   <= '0;
            tstart_reg <= '0;
            tline_reg  <= LINE1;
            pos_reg    <= '0;
            line_reg   <= LINE1;
        end else if (accept) begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            kw_reg     <= kw_next;
            tlen_reg   <= tlen_next;
            tstart_reg <= tstart_next;
            tline_reg  <= tline_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
        end
    end

    // entry = {two tokens, second, first}
    assign push  = accept && (f_v || s_v);
    assign entry = {f_v && s_v,
                    s_tag, s_line, s_start, s_len,
                    f_v ? {f_tag, f_line, f_start, f_len} : {s_tag, s_line, s_start, s_len}};

endmodule

`default_nettype wire

@@ sv/stt_queue.sv @@
// ----------------------------------------------------------------------------
// stt_queue
// Short FIFO of token-pair entries between the lexer and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_queue #(
    parameter int  POS_BITS  = stt_pkg::POS_BITS_DEF,
    parameter int  LINE_BITS = stt_pkg::LINE_BITS_DEF,
    localparam int TOK_W     = stt_pkg::TAG_W + LINE_BITS + 2 * POS_BITS,
    localparam int ENT_W     = 2 * TOK_W + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [ENT_W-1:0]    wdata,
    input  logic                pop,
    output logic [ENT_W-1:0]    rdata,
    output stt_pkg::stt_qstat_t stat
);

    import stt_pkg::*;

    logic [ENT_W-1:0] slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wptr_reg, rptr_reg;
    logic [Q_AW:0]    cnt_reg,  cnt_next;
    logic             do_push, do_pop;

    assign stat.full  = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = slot_reg[rptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + (Q_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wptr_reg <= wptr_reg + Q_AW'(1);
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + Q_AW'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ sv/stt_back.sv @@
// ----------------------------------------------------------------------------
// stt_back
// Output stage: split each queued entry into tokens and hold one token in
// the output register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_back #(
    parameter int  POS_BITS  = stt_pkg::POS_BITS_DEF,
    parameter int  LINE_BITS = stt_pkg::LINE_BITS_DEF,
    localparam int TOK_W     = stt_pkg::TAG_W + LINE_BITS + 2 * POS_BITS,
    localparam int ENT_W     = 2 * TOK_W + 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ENT_W-1:0]           head,
    input  stt_pkg::stt_qstat_t        stat,
    output logic                       pop,
    output logic                       valid,
    input  logic                       ready,
    output logic [stt_pkg::KIND_W-1:0] kind,
    output logic [LINE_BITS-1:0]       tok_line,
    output logic [POS_BITS-1:0]        start_res,
    output logic [POS_BITS-1:0]        length,
    output logic [stt_pkg::ERR_W-1:0]  err,
    output logic                       last
);

    import stt_pkg::*;

    logic             vld_reg;
    logic             sel_reg;
    logic [TOK_W-1:0] tok_reg;
    logic             last_reg;
    logic             free, load, two;
    stt_tag_t         tag;

    assign two  = head[ENT_W-1];
    assign free = !vld_reg || ready;
    assign load = free && !stat.empty;
    // drop the entry once its final token is loaded
    assign pop  = load && (sel_reg || !two);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
            sel_reg <= 1'b0;
        end else begin
            if (free) begin
                vld_reg <= load;
            end
            if (load) begin
                sel_reg <= two && !sel_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            tok_reg  <= sel_reg ? head[2*TOK_W-1:TOK_W] : head[TOK_W-1:0];
            last_reg <= pop;
        end
    end

    assign {tag, tok_line, start_res, length} = tok_reg;
    assign kind  = tag.kind;
    assign err   = tag.err;
    assign valid = vld_reg;
    assign last  = last_reg;

endmodule

`default_nettype wire

@@ sv/source_text_tokenizer.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: source bytes in, token descriptors (kind, line, start,
// length, error) out.
// ----------------------------------------------------------------------------
// Usage:
//   text   - one word per source byte; is_end set marks the end of a source
//            (ch ignored), which flushes the open token and emits EOF unless an error halts.
//   tokens - one word per token. last marks the final token caused by one
//            input word. An error token (kind EOF, err nonzero) halts the
//            block: later input words are taken and dropped until reset.
// Flow:
//   One input word per cycle while the queue has room. A token is written to
//   the queue when the byte that completes it is taken, then passes through
//   the output register to tokens. A byte that closes one token and emits
//   another puts both in one queue entry, handed out one after the other.
//   The lexer writes token pairs into a four-entry queue; text.ready falls
//   only while that queue is full, so a stalled receiver backs up into the
//   queue first and then into the source.
// Reset: rst_n clears the lexer to idle, line 1, offset 0, and empties the
//   queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer #(
    parameter int POS_BITS  = stt_pkg::POS_BITS_DEF,
    parameter int LINE_BITS = stt_pkg::LINE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    stt_byte_if.sink    text,
    stt_token_if.source tokens
);

    import stt_pkg::*;

    localparam int TOK_W = TAG_W + LINE_BITS + 2 * POS_BITS;
    localparam int ENT_W = 2 * TOK_W + 1;

    logic             accept;
    logic             push;
    logic             pop;
    logic [ENT_W-1:0] entry;
    logic [ENT_W-1:0] head;
    stt_qstat_t       qstat;

    // take a byte whenever the queue has room for its tokens
    assign text.ready = !qstat.full;
    assign accept     = text.valid && text.ready;

    stt_front #(
        .POS_BITS  (POS_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .ch     (text.ch),
        .is_end (text.is_end),
        .push   (push),
        .entry  (entry)
    );

    stt_queue #(
        .POS_BITS  (POS_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (entry),
        .pop   (pop),
        .rdata (head),
        .stat  (qstat)
    );

    stt_back #(
        .POS_BITS  (POS_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .stat      (qstat),
        .pop       (pop),
        .valid     (tokens.valid),
        .ready     (tokens.ready),
        .kind      (tokens.kind),
        .tok_line  (tokens.tok_line),
        .start_res (tokens.start_res),
        .length    (tokens.length),
        .err       (tokens.err),
        .last      (tokens.last)
    );

endmodule

`default_nettype wire

@@ sv/stt_checker.sv @@
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks on the token channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_checker #(
    parameter int POS_BITS  = stt_pkg::POS_BITS_DEF,
    parameter int LINE_BITS = stt_pkg::LINE_BITS_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       valid,
    input logic                       ready,
    input logic [stt_pkg::KIND_W-1:0] kind,
    input logic [LINE_BITS-1:0]       tok_line,
    input logic [POS_BITS-1:0]        start_res,
    input logic [POS_BITS-1:0]        length,
    input logic [stt_pkg::ERR_W-1:0]  err,
    input logic                       last
);

    import stt_pkg::*;

    // hold a stalled token
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable({kind, tok_line, start_res, length, err, last}))
        else $error("token changed while stalled");

    // error tokens are EOF-kind, empty and final
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (err != E_NONE) |-> (kind == K_EOF) && (length == '0) && last)
        else $error("malformed error token");

    // EOF is always the final token of its word and empty
    a_eof: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (kind == K_EOF) |-> last && (length == '0))
        else $error("malformed EOF token");

    // operators are one or two characters long
    a_oplen: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (kind >= K_ASSIGN) |->
            (kind <= K_COMMA) && ((length == POS_BITS'(1)) || (length == POS_BITS'(2))))
        else $error("bad operator token");

endmodule

bind source_text_tokenizer stt_checker #(
    .POS_BITS  (POS_BITS),
    .LINE_BITS (LINE_BITS)
) u_stt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (tokens.valid),
    .ready     (tokens.ready),
    .kind      (tokens.kind),
    .tok_line  (tokens.tok_line),
    .start_res (tokens.start_res),
    .length    (tokens.length),
    .err       (tokens.err),
    .last      (tokens.last)
);

`default_nettype wire
